[design/sra_pkg.sv]
package sra_pkg;

  localparam int TIME_W = 32;
  localparam int TEMP_W = 16;
  localparam int SUM_W  = 32;
  localparam int CFG_W  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam int REG_IDX_BIT = 2;
  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_SPIKE    = 1'b1;

  localparam logic [CFG_W-1:0] INTERVAL_RST = 16'd1000;
  localparam logic [CFG_W-1:0] SPIKE_RST    = 16'd240;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic signed [TEMP_W-1:0] ONE_DEGREE = 16'sd16;

  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [CFG_W-1:0] interval;
    logic [CFG_W-1:0] spike;
  } sra_cfg_t;

  typedef struct packed {
    logic load_item;
    logic finish_item;
    logic read_start;
    logic div_step;
    logic finish_div;
  } sra_cmd_t;

  typedef struct packed {
    logic is_read;
    logic count_zero;
  } sra_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } sra_state_t;

endpackage

[design/sra_if.sv]
interface sra_in_if;
  import sra_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [TIME_W-1:0]        now_ms;
  logic signed [TEMP_W-1:0] sample_temp;
  logic                     sample_ok;
  logic signed [TEMP_W-1:0] fallback_temp;

  modport source (
    output valid, cmd, now_ms, sample_temp, sample_ok, fallback_temp,
    input  ready
  );

  modport sink (
    input  valid, cmd, now_ms, sample_temp, sample_ok, fallback_temp,
    output ready
  );
endinterface

interface sra_out_if;
  import sra_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] avg_temp;
  logic                     fresh;
  logic                     accepted;

  modport source (
    output valid, avg_temp, fresh, accepted,
    input  ready
  );

  modport sink (
    input  valid, avg_temp, fresh, accepted,
    output ready
  );
endinterface

[design/sra_regs.sv]
module sra_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sra_pkg::ADDR_W-1:0]   paddr,
  input  logic [sra_pkg::DATA_W-1:0]   pwdata,
  output logic [sra_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output sra_pkg::sra_cfg_t            cfg
);
  import sra_pkg::*;

  logic reg_idx;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_IDX_BIT];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval <= INTERVAL_RST;
      cfg.spike    <= SPIKE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_INTERVAL: cfg.interval <= pwdata[CFG_W-1:0];
        REG_SPIKE:    cfg.spike    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INTERVAL: prdata = {{(DATA_W-CFG_W){1'b0}}, cfg.interval};
      REG_SPIKE:    prdata = {{(DATA_W-CFG_W){1'b0}}, cfg.spike};
      default:      prdata = '0;
    endcase
  end
endmodule

[design/sra_ctrl.sv]
module sra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sra_pkg::sra_stat_t  stat,
  output sra_pkg::sra_cmd_t   ctl
);
  import sra_pkg::*;

  sra_state_t           state;
  sra_state_t           state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_item = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.is_read && !stat.count_zero) begin
          ctl.read_start = 1'b1;
          state_next     = ST_DIV;
        end else if (out_free) begin
          ctl.finish_item = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ctl.finish_div = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      div_cnt   <= '0;
    end else begin
      state     <= state_next;
      out_valid <= ctl.finish_item || ctl.finish_div || (out_valid && !out_ready);
      div_cnt   <= ctl.div_step ? div_cnt + 1'b1 : '0;
    end
  end
endmodule

[design/sra_dp.sv]
module sra_dp #(
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sra_pkg::sra_cmd_t                 ctl,
  output sra_pkg::sra_stat_t                stat,
  input  sra_pkg::sra_cfg_t                 cfg,
  input  logic                              in_cmd,
  input  logic [sra_pkg::TIME_W-1:0]        in_now_ms,
  input  logic signed [sra_pkg::TEMP_W-1:0] in_sample_temp,
  input  logic                              in_sample_ok,
  input  logic signed [sra_pkg::TEMP_W-1:0] in_fallback_temp,
  output logic signed [sra_pkg::TEMP_W-1:0] avg_temp,
  output logic                              fresh,
  output logic                              accepted
);
  import sra_pkg::*;

  logic                     item_cmd;
  logic [TIME_W-1:0]        item_now;
  logic signed [TEMP_W-1:0] item_temp;
  logic                     item_ok;
  logic signed [TEMP_W-1:0] item_fallback;

  logic signed [TEMP_W-1:0] last_accepted;
  logic signed [SUM_W-1:0]  running_sum;
  logic [COUNT_BITS-1:0]    sample_count;
  logic [TIME_W-1:0]        last_sample_time;

  logic [SUM_W-1:0]         div_quo;
  logic [COUNT_BITS-1:0]    div_rem;
  logic [COUNT_BITS-1:0]    div_den;
  logic                     div_neg;

  logic [TIME_W:0]          time_diff;
  logic [TIME_W-1:0]        dt;
  logic                     considered;
  logic [TEMP_W:0]          temp_diff;
  logic [TEMP_W:0]          jump;
  logic                     near;
  logic                     low_last;
  logic [SUM_W:0]           sum_next;
  logic                     sum_ovf;
  logic                     count_full;
  logic                     take;
  logic [SUM_W-1:0]         sum_mag;
  logic [COUNT_BITS+1:0]    trial;
  logic                     fits;
  logic [COUNT_BITS-1:0]    rem_next;

  assign stat.is_read    = (item_cmd == CMD_READ);
  assign stat.count_zero = (sample_count == '0);

  // sample qualification
  assign time_diff  = {1'b0, item_now} - {1'b0, last_sample_time};
  assign dt         = time_diff[TIME_W] ? (~time_diff[TIME_W-1:0] + 1'b1)
                                        : time_diff[TIME_W-1:0];
  assign considered = item_ok && (dt >= {{(TIME_W-CFG_W){1'b0}}, cfg.interval});
  assign temp_diff  = {item_temp[TEMP_W-1], item_temp}
                    - {last_accepted[TEMP_W-1], last_accepted};
  assign jump       = temp_diff[TEMP_W] ? (~temp_diff + 1'b1) : temp_diff;
  assign near       = jump < {1'b0, cfg.spike};
  assign low_last   = last_accepted < ONE_DEGREE;
  assign sum_next   = {running_sum[SUM_W-1], running_sum}
                    + {{(SUM_W-TEMP_W+1){item_temp[TEMP_W-1]}}, item_temp};
  assign sum_ovf    = sum_next[SUM_W] ^ sum_next[SUM_W-1];
  assign count_full = &sample_count;
  assign take       = considered && (near || low_last) && !count_full && !sum_ovf;

  // restoring divider, one quotient bit per cycle
  assign sum_mag  = running_sum[SUM_W-1] ? (~running_sum + 1'b1) : running_sum;
  assign trial    = {1'b0, div_rem, div_quo[SUM_W-1]} - {2'b00, div_den};
  assign fits     = !trial[COUNT_BITS+1];
  assign rem_next = fits ? trial[COUNT_BITS-1:0]
                         : {div_rem[COUNT_BITS-2:0], div_quo[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_accepted    <= '0;
      running_sum      <= '0;
      sample_count     <= '0;
      last_sample_time <= '0;
    end else if (ctl.read_start) begin
      running_sum  <= '0;
      sample_count <= '0;
    end else if (ctl.finish_item && item_cmd == CMD_SAMPLE && considered) begin
      last_sample_time <= item_now;
      if (take) begin
        running_sum   <= sum_next[SUM_W-1:0];
        sample_count  <= sample_count + 1'b1;
        last_accepted <= item_temp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item_cmd      <= in_cmd;
      item_now      <= in_now_ms;
      item_temp     <= in_sample_temp;
      item_ok       <= in_sample_ok;
      item_fallback <= in_fallback_temp;
    end
    if (ctl.read_start) begin
      div_quo <= sum_mag;
      div_rem <= '0;
      div_den <= sample_count;
      div_neg <= running_sum[SUM_W-1];
    end else if (ctl.div_step) begin
      div_quo <= {div_quo[SUM_W-2:0], fits};
      div_rem <= rem_next;
    end
    if (ctl.finish_item) begin
      if (item_cmd == CMD_READ) begin
        avg_temp <= item_fallback;
        accepted <= 1'b0;
      end else begin
        avg_temp <= '0;
        accepted <= take;
      end
      fresh <= 1'b0;
    end else if (ctl.finish_div) begin
      avg_temp <= div_neg ? (~div_quo[TEMP_W-1:0] + 1'b1) : div_quo[TEMP_W-1:0];
      fresh    <= 1'b1;
      accepted <= 1'b0;
    end
  end
endmodule

[design/spike_rejecting_sample_averager_core.sv]
// Averages temperature samples in 1/16 degree units with spike rejection. Each
// input word either offers a sample (cmd 0) or reads and clears the average
// (cmd 1), and yields exactly one output word. A word is taken when the block
// is free and held in an input register, so a new word can be taken while the
// previous result still waits on the output. A sample offer goes from the input
// register through the EXEC state to the result register; a read with samples
// accumulated runs the restoring divider that forms one quotient bit per clock
// over the 32-bit sum, then DONE; an empty read goes as a sample offer. One word
// is in work at a time. The interval and spike limit registers sit on the
// APB-style port at byte addresses 0 and 4 and should be written while idle.
module spike_rejecting_sample_averager_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  sra_in_if.sink                     in_ch,
  sra_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sra_pkg::ADDR_W-1:0] paddr,
  input  logic [sra_pkg::DATA_W-1:0] pwdata,
  output logic [sra_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import sra_pkg::*;

  sra_cfg_t  cfg;
  sra_cmd_t  ctl;
  sra_stat_t stat;

  sra_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  sra_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .stat             (stat),
    .cfg              (cfg),
    .in_cmd           (in_ch.cmd),
    .in_now_ms        (in_ch.now_ms),
    .in_sample_temp   (in_ch.sample_temp),
    .in_sample_ok     (in_ch.sample_ok),
    .in_fallback_temp (in_ch.fallback_temp),
    .avg_temp         (out_ch.avg_temp),
    .fresh            (out_ch.fresh),
    .accepted         (out_ch.accepted)
  );
endmodule

[design/sra_checker.sv]
module sra_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [sra_pkg::TEMP_W-1:0] avg_temp,
  input logic                              fresh,
  input logic                              accepted
);
  import sra_pkg::*;

  // one word in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on two consecutive cycles");

  a_fresh_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(fresh && accepted))
    else $error("fresh and accepted both set");

  a_accept_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> avg_temp == '0)
    else $error("accepted sample word with nonzero average");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(avg_temp)
      && $stable(fresh) && $stable(accepted))
    else $error("output word changed while stalled");
endmodule

bind spike_rejecting_sample_averager_core sra_checker u_sra_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .avg_temp  (out_ch.avg_temp),
  .fresh     (out_ch.fresh),
  .accepted  (out_ch.accepted)
);
